// ===== src/sks_pkg.sv =====
package sks_pkg;

   localparam int unsigned KEY_HALF_W = 64;
   localparam int unsigned KEY_W      = 2 * KEY_HALF_W;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned COUNT_W    = 9;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_MISS  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;
   localparam status_type ST_FULL  = 2'd3;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef struct packed {
      logic entry_below;
      logic entry_above;
   } cmp_res_type;

endpackage

// ===== src/sks_req_if.sv =====
interface sks_req_if
   import sks_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [KEY_HALF_W-1:0] key_high;
   logic [KEY_HALF_W-1:0] key_low;

   modport source (output valid, req_type, key_high, key_low, input ready);
   modport sink   (input valid, req_type, key_high, key_low, output ready);
endinterface

// ===== src/sks_rsp_if.sv =====
interface sks_rsp_if
   import sks_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] result_status;
   logic [POS_W-1:0]    position;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, result_status, position, entry_count, input ready);
   modport sink   (input valid, result_status, position, entry_count, output ready);
endinterface

// ===== src/sks_ram.sv =====
module sks_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/sks_key_cmp.sv =====
module sks_key_cmp
   import sks_pkg::*;
(
   input  key_type     entry,
   input  key_type     key,
   output cmp_res_type res
);
   assign res.entry_below = entry < key;
   assign res.entry_above = entry > key;
endmodule

// ===== src/sorted_key_set_insert_lookup_core.sv =====
// Sorted set of up to CAPACITY distinct 128-bit keys, held in descending unsigned order in one
// single-port-write, registered-read RAM. Each request word is a lookup or an insert; both run a
// binary search through a shared 128-bit comparator, each probe reading the middle entry and then
// comparing it with the key. An insert of a new key then moves every later entry up one place,
// each by a read and then a write through the RAM port, and writes the key into the gap. An
// all-zero key is rejected. req_bus is ready only between requests; one response word per
// request leaves through a register, and the next request is taken while that word waits.
module sorted_key_set_insert_lookup_core
   import sks_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  logic       clock,
   input  logic       reset,
   sks_req_if.sink    req_bus,
   sks_rsp_if.source  rsp_bus
);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE,
      S_DONE
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] lo_ff;
   logic [CW-1:0] hi_ff;
   logic [CW-1:0] mid_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] pos_ff;
   key_type       key_ff;
   logic          insert_ff;
   status_type    status_ff;

   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid_in;
   logic [CW-1:0] idx_dec;
   key_type       req_key;
   key_type       rd_data;
   cmp_res_type   cmp_res;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   key_type       ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [CW+POS_W-1:0]   pos_wide;
   logic [CW+COUNT_W-1:0] count_wide;
   logic          rsp_load;

   assign req_key = {req_bus.key_high, req_bus.key_low};
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in  = mid_sum[CW:1];
   assign idx_dec = idx_ff - CW'(1);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = rd_data;
      ram_rd_addr = mid_in[AW-1:0];
      case (state_ff)
         S_SHIFT_RD: ram_rd_addr = idx_dec[AW-1:0];
         S_SHIFT_WR: ram_wr_en = 1'b1;
         S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff[AW-1:0];
            ram_wr_data = key_ff;
         end
         default: ram_wr_en = 1'b0;
      endcase
   end

   sks_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   sks_key_cmp u_cmp (
      .entry (rd_data),
      .key   (key_ff),
      .res   (cmp_res)
   );

   assign pos_wide   = {{POS_W{1'b0}}, pos_ff};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  key_ff    <= req_key;
                  insert_ff <= req_bus.req_type;
                  lo_ff     <= '0;
                  hi_ff     <= count_ff;
                  if (req_key == '0) begin
                     status_ff <= ST_EMPTY;
                     pos_ff    <= '0;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= S_CMP;
               end else if (insert_ff != REQ_INSERT) begin
                  status_ff <= ST_MISS;
                  pos_ff    <= '0;
                  state_ff  <= S_DONE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_ff <= ST_FULL;
                  pos_ff    <= '0;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= count_ff;
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_CMP: begin
               if (cmp_res.entry_below) begin
                  hi_ff    <= mid_ff;
                  state_ff <= S_PROBE;
               end else if (cmp_res.entry_above) begin
                  lo_ff    <= mid_ff + CW'(1);
                  state_ff <= S_PROBE;
               end else begin
                  status_ff <= (insert_ff == REQ_INSERT) ? ST_MISS : ST_OK;
                  pos_ff    <= mid_ff;
                  state_ff  <= S_DONE;
               end
            end
            S_SHIFT_RD: begin
               state_ff <= (idx_ff > lo_ff) ? S_SHIFT_WR : S_WRITE;
            end
            S_SHIFT_WR: begin
               idx_ff   <= idx_dec;
               state_ff <= S_SHIFT_RD;
            end
            S_WRITE: begin
               count_ff  <= count_ff + CW'(1);
               status_ff <= ST_OK;
               pos_ff    <= lo_ff;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_status_ff <= status_ff;
                  rsp_pos_ff    <= pos_wide[POS_W-1:0];
                  rsp_count_ff  <= count_wide[COUNT_W-1:0];
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.result_status = rsp_status_ff;
   assign rsp_bus.position      = rsp_pos_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> count_ff == $past(count_ff) + CW'(1))
      else $error("entry count moved by other than one");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE || state_ff == S_CMP) |-> lo_ff <= hi_ff)
      else $error("search window inverted");

   a_empty_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EMPTY || rsp_status_ff == ST_FULL))
         |-> rsp_pos_ff == '0)
      else $error("rejected word carries a position");
endmodule

// ===== bench/sks_outcome_checker.sv =====
module sks_outcome_checker
   import sks_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  logic clock,
   input  logic reset,
   sks_req_if   req_bus,
   sks_rsp_if   rsp_bus,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   logic [KEY_HALF_W-1:0] upper_keys [CAPACITY];
   logic [KEY_HALF_W-1:0] lower_keys [CAPACITY];
   int unsigned           held = 0;
   outcome_type           expected_q [$];
   int                    mismatches = 0;

   function automatic outcome_type search_and_insert(logic op, logic [KEY_HALF_W-1:0] kh,
                                                     logic [KEY_HALF_W-1:0] kl);
      outcome_type o;
      key_type     k;
      key_type     e;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic        hit;
      o   = '0;
      k   = {kh, kl};
      lo  = 0;
      hi  = held;
      hit = 1'b0;
      if (k == '0) begin
         o.status = ST_EMPTY;
      end else begin
         while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            e   = {upper_keys[mid], lower_keys[mid]};
            if (e < k) begin
               hi = mid;
            end else if (e > k) begin
               lo = mid + 1;
            end else begin
               hit        = 1'b1;
               o.position = mid[POS_W-1:0];
            end
         end
         if (op == REQ_LOOKUP) begin
            o.status = hit ? ST_OK : ST_MISS;
         end else if (hit) begin
            o.status = ST_MISS;
         end else if (held >= CAPACITY) begin
            o.status = ST_FULL;
         end else begin
            for (int i = held; i > lo; i--) begin
               upper_keys[i] = upper_keys[i-1];
               lower_keys[i] = lower_keys[i-1];
            end
            upper_keys[lo] = kh;
            lower_keys[lo] = kl;
            held++;
            o.status   = ST_OK;
            o.position = lo[POS_W-1:0];
         end
      end
      o.count = held[COUNT_W-1:0];
      return o;
   endfunction

   task automatic report(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         held = 0;
         expected_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected word, status %0d position %0d count %0d", $time,
                        rsp_bus.result_status, rsp_bus.position, rsp_bus.entry_count);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.result_status !== want.status)
                  report("status", COUNT_W'(want.status), COUNT_W'(rsp_bus.result_status));
               if (rsp_bus.position !== want.position)
                  report("position", COUNT_W'(want.position), COUNT_W'(rsp_bus.position));
               if (rsp_bus.entry_count !== want.count)
                  report("entry count", want.count, rsp_bus.entry_count);
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_q.push_back(search_and_insert(req_bus.req_type, req_bus.key_high,
                                                   req_bus.key_low));
      end
      fail_count  <= mismatches;
      outstanding <= expected_q.size();
   end

endmodule

// ===== bench/sorted_key_set_insert_lookup_core_tb.sv =====
module sorted_key_set_insert_lookup_core_tb;
   import sks_pkg::*;

   localparam int unsigned CAPACITY        = 256;
   localparam int unsigned PHASE_WORDS     = 183;
   localparam int unsigned HOLD_OFF_CYCLES = 3000;
   localparam int unsigned DRAIN_LIMIT     = 5000;
   localparam int unsigned SETTLE_CYCLES   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   int unsigned hold_request  = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int          fail_count;
   int          outstanding;
   key_type     held_keys [$];

   sks_req_if req_bus ();
   sks_rsp_if rsp_bus ();

   sorted_key_set_insert_lookup_core #(.CAPACITY(CAPACITY)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sks_outcome_checker #(.CAPACITY(CAPACITY)) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("** sorted_key_set_insert_lookup_core: FAILED **");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_left = hold_request;
         hold_seen = hold_request;
      end
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // fresh and tiny keys, plus hits, near neighbours and part-redrawn copies of held keys
   function automatic key_type draw_key();
      key_type     k;
      int unsigned sel;
      int unsigned word_idx;
      sel      = $urandom_range(99);
      word_idx = $urandom_range(3);
      if (sel < 5) begin
         k = key_type'($urandom_range(3));
      end else if (held_keys.size() == 0 || sel < 40) begin
         k = {$urandom(), $urandom(), $urandom(), $urandom()};
      end else begin
         k = held_keys[$urandom_range(held_keys.size() - 1)];
         if (sel < 60)
            k = k;
         else if (sel < 72)
            k = k + key_type'(1);
         else if (sel < 84)
            k = k - key_type'(1);
         else if (sel < 94)
            k[32*word_idx +: 32] = $urandom();
         else
            k[KEY_HALF_W-1:0] = {$urandom(), $urandom()};
      end
      return k;
   endfunction

   task automatic send_word(logic op, key_type k);
      int unsigned gap;
      gap = 0;
      while (gap < 200 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= op;
      req_bus.key_high <= k[KEY_W-1:KEY_HALF_W];
      req_bus.key_low  <= k[KEY_HALF_W-1:0];
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (op == REQ_INSERT && k != '0)
         held_keys.push_back(k);
   endtask

   task automatic send_random();
      send_word(($urandom_range(99) < 70) ? REQ_INSERT : REQ_LOOKUP, draw_key());
   endtask

   initial begin
      int unsigned n;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_LOOKUP;
      req_bus.key_high = '0;
      req_bus.key_low  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      take_idle_pct = 78;
      send_word(REQ_LOOKUP, '0);
      send_word(REQ_INSERT, '0);
      send_word(REQ_LOOKUP, '1);
      send_word(REQ_INSERT, '1);
      send_word(REQ_INSERT, key_type'(1));
      send_word(REQ_INSERT, {64'd1, 64'd0});
      send_word(REQ_INSERT, {64'd0, {64{1'b1}}});
      send_word(REQ_INSERT, {{64{1'b1}}, 64'd0});
      send_word(REQ_INSERT, {1'b1, 127'd0});
      send_word(REQ_INSERT, {{127{1'b1}}, 1'b0});
      send_word(REQ_INSERT, '1);
      send_word(REQ_INSERT, key_type'(1));
      send_word(REQ_LOOKUP, '1);
      send_word(REQ_LOOKUP, key_type'(1));
      send_word(REQ_LOOKUP, key_type'(2));
      send_word(REQ_LOOKUP, {64'd1, 64'd0});
      send_word(REQ_LOOKUP, {64'd1, 64'd1});
      send_word(REQ_INSERT, {64'd1, 64'd1});
      send_word(REQ_LOOKUP, {64'd1, 64'd1});
      send_word(REQ_LOOKUP, '0);
      send_word(REQ_INSERT, '0);
      for (n = 0; n < PHASE_WORDS; n++)
         send_random();

      send_idle_pct = 78;
      take_idle_pct = 6;
      for (n = 0; n < PHASE_WORDS; n++)
         send_random();

      // hold the response side off so the block backs up onto its input
      send_idle_pct = 0;
      take_idle_pct = 0;
      hold_request  = HOLD_OFF_CYCLES;
      for (n = 0; n < PHASE_WORDS; n++)
         send_random();

      @(negedge clock);
      req_bus.valid <= 1'b0;

      n = 0;
      while (outstanding != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outstanding != 0)
         $display("%0t: %0d responses never arrived", $time, outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("** sorted_key_set_insert_lookup_core: PASSED **");
      else
         $display("** sorted_key_set_insert_lookup_core: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
src/sks_pkg.sv
src/sks_req_if.sv
src/sks_rsp_if.sv
src/sks_ram.sv
src/sks_key_cmp.sv
src/sorted_key_set_insert_lookup_core.sv
bench/sks_outcome_checker.sv
bench/sorted_key_set_insert_lookup_core_tb.sv
